FILE: design/ffba_pkg.sv
package ffba_pkg;

   localparam int NUM_ENTRIES   = 4096;
   localparam int BITS_PER_WORD = 8;
   localparam int IDX_W         = 12;

   localparam int WORD_COUNT = (NUM_ENTRIES + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W      = $clog2(BITS_PER_WORD);
   localparam int LAST_VALID = NUM_ENTRIES - (WORD_COUNT - 1) * BITS_PER_WORD;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);
   localparam logic [BITS_PER_WORD-1:0] LAST_MASK =
      {BITS_PER_WORD{1'b1}} >> (BITS_PER_WORD - LAST_VALID);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic scan_start;
      logic scan_read;
      logic alloc_commit;
      logic set_full;
      logic free_latch;
      logic free_read;
      logic free_commit;
      logic free_bad;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic data_valid;
      logic has_free;
      logic data_last;
      logic index_ok;
      logic out_open;
   } status_type;

endpackage

FILE: design/first_free_bitmap_allocator.sv
// Allocate: scans W bitmap words (1 to 512) until one has a free bit or the last is
// read, one word per cycle through the bitmap memory. Free: rewrites the word with the
// bit cleared; an out-of-range index is refused. One item in flight; the next item is
// taken once the result is in the output register. Reset is synchronous; afterwards a
// clearing pass zeroes all 512 bitmap words, with req_stall held high until it ends.
module first_free_bitmap_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic [ffba_pkg::IDX_W-1:0] req_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [ffba_pkg::IDX_W-1:0] rsp_granted_index,
   output logic                       rsp_is_full
);

   ffba_pkg::cmd_type    cmd;
   ffba_pkg::status_type status;

   ffba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   ffba_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_index         (req_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_granted_index (rsp_granted_index),
      .rsp_is_full       (rsp_is_full)
   );

endmodule

FILE: design/ffba_dp.sv
module ffba_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ffba_pkg::cmd_type             cmd,
   output ffba_pkg::status_type          status,
   input  logic [ffba_pkg::IDX_W-1:0]    req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [ffba_pkg::IDX_W-1:0]    rsp_granted_index,
   output logic                          rsp_is_full
);

   logic [ffba_pkg::BITS_PER_WORD-1:0] mem [ffba_pkg::WORD_COUNT];

   logic [ffba_pkg::ADDR_W-1:0]        addr_ff, addr_in;
   logic [ffba_pkg::ADDR_W-1:0]        addr_q_ff;
   logic                               pv_ff, pv_in;
   logic [ffba_pkg::BITS_PER_WORD-1:0] rdata_ff;
   logic [ffba_pkg::ADDR_W-1:0]        fword_ff;
   logic [ffba_pkg::BIT_W-1:0]         fbit_ff;
   logic                               res_found_ff;
   logic [ffba_pkg::IDX_W-1:0]         res_index_ff;
   logic                               res_full_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff;
   logic [ffba_pkg::IDX_W-1:0]         rsp_index_ff;
   logic                               rsp_full_ff;

   logic [ffba_pkg::BITS_PER_WORD-1:0] free_bits;
   logic [ffba_pkg::BITS_PER_WORD-1:0] pick_onehot;
   logic [ffba_pkg::BIT_W-1:0]         pick;
   logic [31:0]                        entry_wide;
   logic [31:0]                        req_word;
   logic [ffba_pkg::ADDR_W-1:0]        rd_addr;
   logic                               rd_en;
   logic [ffba_pkg::ADDR_W-1:0]        wr_addr;
   logic [ffba_pkg::BITS_PER_WORD-1:0] wr_data;
   logic                               wr_en;

   // free bits of the returned word, padding bits count as taken
   always_comb begin
      free_bits = ~rdata_ff;
      if (addr_q_ff == ffba_pkg::LAST_ADDR) begin
         free_bits = free_bits & ffba_pkg::LAST_MASK;
      end
      pick = '0;
      for (int i = ffba_pkg::BITS_PER_WORD - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            pick = ffba_pkg::BIT_W'(i);
         end
      end
      pick_onehot = ffba_pkg::BITS_PER_WORD'(1) << pick;
      entry_wide  = 32'({addr_q_ff, pick});
      req_word    = 32'(req_index) >> ffba_pkg::BIT_W;
   end

   always_comb begin
      rd_en   = cmd.scan_read | cmd.free_read;
      rd_addr = cmd.free_read ? fword_ff : addr_ff;
      wr_en   = cmd.clear_step | cmd.alloc_commit | cmd.free_commit;
      wr_addr = addr_ff;
      wr_data = '0;
      if (cmd.alloc_commit) begin
         wr_addr = addr_q_ff;
         wr_data = rdata_ff | pick_onehot;
      end else if (cmd.free_commit) begin
         wr_addr = fword_ff;
         wr_data = rdata_ff & ~(ffba_pkg::BITS_PER_WORD'(1) << fbit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.scan_start) begin
         addr_in = '0;
      end else if ((cmd.clear_step | cmd.scan_read) && addr_ff != ffba_pkg::LAST_ADDR) begin
         addr_in = addr_ff + 1'b1;
      end
      pv_in = cmd.scan_start ? 1'b0 : cmd.scan_read;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         addr_q_ff <= addr_ff;
      end
      if (cmd.free_latch) begin
         fword_ff <= req_word[ffba_pkg::ADDR_W-1:0];
         fbit_ff  <= req_index[ffba_pkg::BIT_W-1:0];
      end
      if (cmd.alloc_commit) begin
         res_found_ff <= 1'b1;
         res_index_ff <= entry_wide[ffba_pkg::IDX_W-1:0];
         res_full_ff  <= 1'b0;
      end else if (cmd.set_full) begin
         res_found_ff <= 1'b0;
         res_index_ff <= '0;
         res_full_ff  <= 1'b1;
      end else if (cmd.free_commit) begin
         res_found_ff <= 1'b1;
         res_index_ff <= '0;
         res_full_ff  <= 1'b0;
      end else if (cmd.free_bad) begin
         res_found_ff <= 1'b0;
         res_index_ff <= '0;
         res_full_ff  <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_index_ff <= res_index_ff;
         rsp_full_ff  <= res_full_ff;
      end
   end

   always_comb begin
      status.clear_done = (addr_ff == ffba_pkg::LAST_ADDR);
      status.data_valid = pv_ff;
      status.has_free   = |free_bits;
      status.data_last  = (addr_q_ff == ffba_pkg::LAST_ADDR);
      status.index_ok   = (32'(req_index) < 32'(ffba_pkg::NUM_ENTRIES));
      status.out_open   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_is_full       = rsp_full_ff;

endmodule

FILE: design/ffba_ctrl.sv
module ffba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  ffba_pkg::status_type status,
   output ffba_pkg::cmd_type    cmd
);

   ffba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ffba_pkg::ST_IDLE);
      case (state_ff)
         ffba_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ffba_pkg::ST_IDLE;
            end
         end
         ffba_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == ffba_pkg::OP_ALLOC) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ffba_pkg::ST_SCAN;
               end else if (status.index_ok) begin
                  cmd.free_latch = 1'b1;
                  state_in       = ffba_pkg::ST_FREE_RD;
               end else begin
                  cmd.free_bad = 1'b1;
                  state_in     = ffba_pkg::ST_FINISH;
               end
            end
         end
         ffba_pkg::ST_SCAN: begin
            if (status.data_valid && status.has_free) begin
               cmd.alloc_commit = 1'b1;
               state_in         = ffba_pkg::ST_FINISH;
            end else if (status.data_valid && status.data_last) begin
               cmd.set_full = 1'b1;
               state_in     = ffba_pkg::ST_FINISH;
            end else begin
               cmd.scan_read = 1'b1;
            end
         end
         ffba_pkg::ST_FREE_RD: begin
            cmd.free_read = 1'b1;
            state_in      = ffba_pkg::ST_FREE_WR;
         end
         ffba_pkg::ST_FREE_WR: begin
            cmd.free_commit = 1'b1;
            state_in        = ffba_pkg::ST_FINISH;
         end
         ffba_pkg::ST_FINISH: begin
            if (status.out_open) begin
               cmd.out_load = 1'b1;
               state_in     = ffba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
